FILE: hdl/dcms_pkg.sv
// dcms_pkg: shared types, register indexes and helpers for the dc motor stiction step
// used by dcms_div, dcms_mul and dc_motor_stiction_model_step
package dcms_pkg;

  localparam int DATA_W    = 32;
  localparam int REG_W     = 31;
  localparam int DT_W      = 17;
  localparam int CFG_IDX_W = 3;
  localparam int SAT_W     = 66;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int DIV_N_W  = 48;
  localparam int DIV_D_W  = 31;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LONG_N  = DIV_CNT_W'(DIV_N_W);
  localparam logic [DIV_CNT_W-1:0] DIV_SHORT_N = DIV_CNT_W'(DIV_D_W);

  localparam int H_W = 22;
  localparam logic [DIV_D_W-1:0] FRIC_GAIN = DIV_D_W'(1000);

  // window = ((friction_torque >> 3) * recip) >> 35, exact floor of /1000 for 31-bit values
  localparam int FRIC_PRE_SHIFT = 3;
  localparam int FRIC_SHIFT     = 35;
  localparam logic signed [MUL_B_W-1:0] FRIC_RECIP = MUL_B_W'(274877907);

  localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION_TORQUE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INERTIA         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_MAX    = 3'd5;

  typedef struct packed {
    logic [DT_W-1:0]          time_step;
    logic signed [DATA_W-1:0] torque_command;
    logic signed [DATA_W-1:0] load_torque;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] applied_torque;
    logic signed [DATA_W-1:0] new_position;
    logic signed [DATA_W-1:0] new_velocity;
    logic signed [DATA_W-1:0] net_torque;
    logic                     at_limit;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic long_op;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(32'sh7fffffff);
    lo = SAT_W'(32'sh80000000);
    if (x > hi) begin
      return 32'sh7fffffff;
    end else if (x < lo) begin
      return 32'sh80000000;
    end
    return x[DATA_W-1:0];
  endfunction

endpackage

FILE: hdl/dc_motor_stiction_model_step.sv
// dc_motor_stiction_model_step: one euler step of a dc motor with stiction per input beat
// each beat walks the sequencer states in order and waits in the divide state for the
// bit-serial inertia divide; a new beat waits until the last result is written back;
// one shared multiplier serves window, friction, damping and both integrations
// a stalled result holds the sequencer in write-back; synchronous active-low reset loads
// register defaults and clears position, velocity, anchor; uses dcms_pkg, dcms_div, dcms_mul
module dc_motor_stiction_model_step (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dcms_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dcms_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [dcms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcms_pkg::DATA_W-1:0]     cfg_data
);
  import dcms_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_HMUL   = 14'b00000000000010,
    ST_HWIN   = 14'b00000000000100,
    ST_ANCHOR = 14'b00000000001000,
    ST_FRIC   = 14'b00000000010000,
    ST_DAMP   = 14'b00000000100000,
    ST_NET    = 14'b00000001000000,
    ST_ASTART = 14'b00000010000000,
    ST_ADIV   = 14'b00000100000000,
    ST_VMUL   = 14'b00001000000000,
    ST_VEL    = 14'b00010000000000,
    ST_PMUL   = 14'b00100000000000,
    ST_POS    = 14'b01000000000000,
    ST_WB     = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [REG_W-1:0]         torque_limit_r;
  logic [REG_W-1:0]         friction_torque_r;
  logic [REG_W-1:0]         damping_r;
  logic [REG_W-1:0]         inertia_r;
  logic signed [DATA_W-1:0] position_min_r;
  logic signed [DATA_W-1:0] position_max_r;

  logic signed [DATA_W-1:0] position_r;
  logic signed [DATA_W-1:0] velocity_r;
  logic signed [DATA_W-1:0] anchor_r;

  in_item_t                 in_r;
  logic [H_W-1:0]           h_r;
  logic signed [DATA_W-1:0] cmd_r;
  logic signed [DATA_W-1:0] fric_r;
  logic signed [DATA_W-1:0] net_r;
  logic signed [DATA_W-1:0] acc_r;
  logic signed [DATA_W-1:0] vel_r;
  out_item_t                res_r;
  out_item_t                out_r;
  logic                     out_valid_r;

  logic                     in_acc;
  logic                     wb_ok;

  div_req_t                 div_rq;
  div_stat_t                div_st;
  logic [DIV_N_W-1:0]       div_dividend;
  logic [DIV_D_W-1:0]       div_divisor;
  logic [DIV_N_W-1:0]       div_q;
  logic [DATA_W-1:0]        net_mag;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [SAT_W-1:0]   prod_q16;

  logic signed [SAT_W-1:0]   pos_s;
  logic signed [SAT_W-1:0]   h_s;
  logic signed [SAT_W-1:0]   diff_s;
  logic signed [SAT_W-1:0]   cmd_s;
  logic signed [SAT_W-1:0]   lim_s;
  logic signed [SAT_W-1:0]   q_s;
  logic signed [SAT_W-1:0]   dt_s;
  logic signed [DATA_W-1:0]  npos_sat;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign wb_ok    = !out_valid_r || !out_stall;

  assign pos_s    = SAT_W'(position_r);
  assign h_s      = $signed({(SAT_W-H_W)'(0), h_r});
  assign diff_s   = pos_s - SAT_W'(anchor_r);
  assign cmd_s    = SAT_W'(in_r.torque_command);
  assign lim_s    = $signed({(SAT_W-REG_W)'(0), torque_limit_r});
  assign q_s      = $signed({(SAT_W-DIV_N_W)'(0), div_q});
  assign dt_s     = $signed({(SAT_W-DT_W)'(0), in_r.time_step});
  assign prod_q16 = SAT_W'(mul_p) >>> 16;
  assign net_mag  = net_r[DATA_W-1] ? (~net_r + 1'b1) : net_r;
  assign npos_sat = sat32(pos_s + prod_q16);

  // divider requests
  always_comb begin
    div_rq.start   = (state_r == ST_ASTART);
    div_rq.long_op = 1'b1;
    div_dividend   = {net_mag, 16'h0000};
    div_divisor    = (inertia_r == '0) ? DIV_D_W'(1) : inertia_r;
  end

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_HMUL: begin
        mul_a = MUL_A_W'(friction_torque_r[REG_W-1:FRIC_PRE_SHIFT]);
        mul_b = FRIC_RECIP;
      end
      ST_FRIC: begin
        mul_a = MUL_A_W'(position_r) - MUL_A_W'(anchor_r);
        mul_b = MUL_B_W'(FRIC_GAIN);
      end
      ST_DAMP: begin
        mul_a = MUL_A_W'(velocity_r);
        mul_b = $signed({1'b0, damping_r});
      end
      ST_VMUL: begin
        mul_a = MUL_A_W'(acc_r);
        mul_b = dt_s[MUL_B_W-1:0];
      end
      ST_PMUL: begin
        mul_a = MUL_A_W'(vel_r);
        mul_b = dt_s[MUL_B_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_HMUL;
      ST_HMUL:   state_nxt = ST_HWIN;
      ST_HWIN:   state_nxt = ST_ANCHOR;
      ST_ANCHOR: state_nxt = ST_FRIC;
      ST_FRIC:   state_nxt = ST_DAMP;
      ST_DAMP:   state_nxt = ST_NET;
      ST_NET:    state_nxt = ST_ASTART;
      ST_ASTART: state_nxt = ST_ADIV;
      ST_ADIV:   if (div_st.done) state_nxt = ST_VMUL;
      ST_VMUL:   state_nxt = ST_VEL;
      ST_VEL:    state_nxt = ST_PMUL;
      ST_PMUL:   state_nxt = ST_POS;
      ST_POS:    state_nxt = ST_WB;
      ST_WB:     if (wb_ok) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      torque_limit_r    <= REG_W'(65536);
      friction_torque_r <= '0;
      damping_r         <= '0;
      inertia_r         <= REG_W'(65536);
      position_min_r    <= '0;
      position_max_r    <= 32'sd102944;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TORQUE_LIMIT:    torque_limit_r    <= cfg_data[REG_W-1:0];
        REG_FRICTION_TORQUE: friction_torque_r <= cfg_data[REG_W-1:0];
        REG_DAMPING:         damping_r         <= cfg_data[REG_W-1:0];
        REG_INERTIA:         inertia_r         <= cfg_data[REG_W-1:0];
        REG_POSITION_MIN:    position_min_r    <= $signed(cfg_data);
        REG_POSITION_MAX:    position_max_r    <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // motor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      velocity_r <= '0;
      anchor_r   <= '0;
    end else begin
      if (state_r == ST_ANCHOR) begin
        if (diff_s < -h_s) begin
          anchor_r <= sat32(pos_s + h_s);
        end else if (diff_s > h_s) begin
          anchor_r <= sat32(pos_s - h_s);
        end
      end
      if (state_r == ST_POS) begin
        if (npos_sat < position_min_r) begin
          position_r <= position_min_r;
          velocity_r <= '0;
        end else if (npos_sat > position_max_r) begin
          position_r <= position_max_r;
          velocity_r <= '0;
        end else begin
          position_r <= npos_sat;
          velocity_r <= vel_r;
        end
      end
    end
  end

  // datapath scratch registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
    if (state_r == ST_HWIN) begin
      h_r <= mul_p[FRIC_SHIFT +: H_W];
    end
    if (state_r == ST_ANCHOR) begin
      if (cmd_s > lim_s) begin
        cmd_r <= lim_s[DATA_W-1:0];
      end else if (cmd_s < -lim_s) begin
        cmd_r <= sat32(-lim_s);
      end else begin
        cmd_r <= in_r.torque_command;
      end
    end
    if (state_r == ST_DAMP) begin
      fric_r <= sat32(SAT_W'(mul_p));
    end
    if (state_r == ST_NET) begin
      net_r <= sat32(SAT_W'(fric_r) - prod_q16 + SAT_W'(cmd_r) + SAT_W'(in_r.load_torque));
    end
    if ((state_r == ST_ADIV) && div_st.done) begin
      acc_r <= sat32(net_r[DATA_W-1] ? -q_s : q_s);
    end
    if (state_r == ST_VEL) begin
      vel_r <= sat32(SAT_W'(velocity_r) + prod_q16);
    end
    if (state_r == ST_POS) begin
      res_r.applied_torque <= cmd_r;
      if (npos_sat < position_min_r) begin
        res_r.new_position <= position_min_r;
        res_r.new_velocity <= '0;
        res_r.net_torque   <= '0;
        res_r.at_limit     <= 1'b1;
      end else if (npos_sat > position_max_r) begin
        res_r.new_position <= position_max_r;
        res_r.new_velocity <= '0;
        res_r.net_torque   <= '0;
        res_r.at_limit     <= 1'b1;
      end else begin
        res_r.new_position <= npos_sat;
        res_r.new_velocity <= vel_r;
        res_r.net_torque   <= net_r;
        res_r.at_limit     <= 1'b0;
      end
    end
    if ((state_r == ST_WB) && wb_ok) begin
      out_r <= res_r;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_WB) && wb_ok) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  dcms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_rq),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_st),
    .quotient (div_q)
  );

  dcms_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  a_limit_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.at_limit) |-> (out_r.net_torque == '0 && out_r.new_velocity == '0))
    else $error("limit beat with non-zero net torque or velocity");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == ST_ADIV))
    else $error("divider finished outside the divide state");

  a_adiv_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADIV) |-> div_st.busy)
    else $error("divide state with the divider not running");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !in_valid) |=> (state_r == ST_IDLE))
    else $error("sequencer left idle without an input beat");

  a_accept_starts_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid) |=> (state_r == ST_HMUL))
    else $error("input beat did not start the window multiply");

endmodule

FILE: hdl/dcms_div.sv
// dcms_div: bit-serial restoring unsigned divider, one quotient bit per cycle
// short run of 31 steps or long run of 48 steps; depends on dcms_pkg
module dcms_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dcms_pkg::div_req_t            req,
  input  logic [dcms_pkg::DIV_N_W-1:0]  dividend,
  input  logic [dcms_pkg::DIV_D_W-1:0]  divisor,
  output dcms_pkg::div_stat_t           stat,
  output logic [dcms_pkg::DIV_N_W-1:0]  quotient
);
  import dcms_pkg::*;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_D_W-1:0]   rem_r;
  logic [DIV_N_W-1:0]   dq_r;
  logic [DIV_D_W-1:0]   dvs_r;

  logic [DIV_D_W:0]     shifted;
  logic [DIV_D_W:0]     trial;
  logic                 ge;

  assign shifted = {rem_r, dq_r[DIV_N_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign trial   = shifted - {1'b0, dvs_r};

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == '0);
  assign quotient  = dq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.long_op ? DIV_LONG_N : DIV_SHORT_N;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      dq_r  <= req.long_op ? dividend
                           : {dividend[DIV_D_W-1:0], (DIV_N_W-DIV_D_W)'(0)};
    end else if (busy_r && (cnt_r != '0)) begin
      rem_r <= ge ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
      dq_r  <= {dq_r[DIV_N_W-2:0], ge};
    end
  end

endmodule

FILE: hdl/dcms_mul.sv
// dcms_mul: shared signed multiplier with registered product
// the product appears in the cycle after its operands; depends on dcms_pkg
module dcms_mul (
  input  logic                                clk,
  input  logic signed [dcms_pkg::MUL_A_W-1:0] a,
  input  logic signed [dcms_pkg::MUL_B_W-1:0] b,
  output logic signed [dcms_pkg::MUL_P_W-1:0] p
);
  import dcms_pkg::*;

  logic signed [MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

  assign p = p_r;

endmodule

FILE: tb/dc_motor_stiction_model_step_check.sv
`timescale 1ns / 100ps
// dc_motor_stiction_model_step_check: watches the input, result and register ports of the
// motor step block, keeps its own euler-step motor state and compares every result beat
// depends on dcms_pkg for the beat types and register indexes
module dc_motor_stiction_model_step_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  dcms_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  dcms_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [dcms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dcms_pkg::DATA_W-1:0]    cfg_data,
  output int                             fail_count,
  output int                             results_due
);
  import dcms_pkg::*;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam longint STICTION_GAIN = 1000;
  localparam int PRINT_CAP = 200;

  longint torque_limit, friction_level, damping, inertia, pos_min, pos_max;
  longint position, velocity, anchor;
  out_item_t motor_results[$];
  int result_idx = 0;

  function automatic longint clamp_q15(input longint x);
    if (x > Q_MAX) return Q_MAX;
    if (x < Q_MIN) return Q_MIN;
    return x;
  endfunction

  function automatic out_item_t advance_motor(input in_item_t beat);
    longint dt, cmd, load, h, diff, fric, damp, net, acc, vel, npos, j;
    logic hit;
    out_item_t res;
    dt = longint'(beat.time_step);
    cmd = longint'($signed(beat.torque_command));
    load = longint'($signed(beat.load_torque));
    if (cmd > torque_limit) cmd = torque_limit;
    if (cmd < -torque_limit) cmd = -torque_limit;

    // anchor trails position within the stiction window
    h = friction_level / STICTION_GAIN;
    diff = position - anchor;
    if (diff < -h) begin
      anchor = clamp_q15(position + h);
    end else if (diff > h) begin
      anchor = clamp_q15(position - h);
    end

    fric = clamp_q15((position - anchor) * STICTION_GAIN);
    damp = (damping * velocity) >>> 16;
    net = clamp_q15(fric - damp + cmd + load);
    j = (inertia == 0) ? 1 : inertia;
    acc = clamp_q15((net * 65536) / j);
    vel = clamp_q15(velocity + ((acc * dt) >>> 16));
    npos = clamp_q15(position + ((vel * dt) >>> 16));

    hit = 1'b0;
    if (npos < pos_min) begin
      npos = pos_min;
      vel = 0;
      hit = 1'b1;
    end else if (npos > pos_max) begin
      npos = pos_max;
      vel = 0;
      hit = 1'b1;
    end
    position = npos;
    velocity = vel;
    if (hit) net = 0;

    res.applied_torque = cmd[DATA_W-1:0];
    res.new_position = npos[DATA_W-1:0];
    res.new_velocity = vel[DATA_W-1:0];
    res.net_torque = net[DATA_W-1:0];
    res.at_limit = hit;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (fail_count < PRINT_CAP) begin
      $display("result %0d: %s got %h want %h", result_idx, what, got, want);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t oldest;
    if (!rst_n) begin
      torque_limit = 65536;
      friction_level = 0;
      damping = 0;
      inertia = 65536;
      pos_min = 0;
      pos_max = 102944;
      position = 0;
      velocity = 0;
      anchor = 0;
      motor_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TORQUE_LIMIT:    torque_limit = longint'(cfg_data[REG_W-1:0]);
          REG_FRICTION_TORQUE: friction_level = longint'(cfg_data[REG_W-1:0]);
          REG_DAMPING:         damping = longint'(cfg_data[REG_W-1:0]);
          REG_INERTIA:         inertia = longint'(cfg_data[REG_W-1:0]);
          REG_POSITION_MIN:    pos_min = longint'($signed(cfg_data));
          REG_POSITION_MAX:    pos_max = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (motor_results.size() == 0) begin
          report_mismatch("result beat with none expected, position",
                          out_data.new_position, '0);
        end else begin
          oldest = motor_results.pop_front();
          if (out_data.applied_torque !== oldest.applied_torque)
            report_mismatch("applied_torque", out_data.applied_torque, oldest.applied_torque);
          if (out_data.new_position !== oldest.new_position)
            report_mismatch("new_position", out_data.new_position, oldest.new_position);
          if (out_data.new_velocity !== oldest.new_velocity)
            report_mismatch("new_velocity", out_data.new_velocity, oldest.new_velocity);
          if (out_data.net_torque !== oldest.net_torque)
            report_mismatch("net_torque", out_data.net_torque, oldest.net_torque);
          if (out_data.at_limit !== oldest.at_limit)
            report_mismatch("at_limit", DATA_W'(out_data.at_limit), DATA_W'(oldest.at_limit));
        end
        result_idx++;
      end
      if (in_valid && !in_stall) begin
        motor_results.push_back(advance_motor(in_data));
      end
    end
    results_due = motor_results.size();
  end

endmodule

FILE: tb/dc_motor_stiction_model_step_test.sv
`timescale 1ns / 100ps
// dc_motor_stiction_model_step_test: clock, reset, register settings and random beats for
// the motor step block; checking is done by dc_motor_stiction_model_step_check
// depends on dcms_pkg, dc_motor_stiction_model_step and dc_motor_stiction_model_step_check
module dc_motor_stiction_model_step_test;
  import dcms_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BEATS = 72;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh00010000;
  localparam logic [REG_W-1:0] REG_MAX = '1;

  typedef struct {
    logic [REG_W-1:0]         torque_limit;
    logic [REG_W-1:0]         friction_torque;
    logic [REG_W-1:0]         damping;
    logic [REG_W-1:0]         inertia;
    logic signed [DATA_W-1:0] position_min;
    logic signed [DATA_W-1:0] position_max;
  } motor_cfg_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_we;
  in_item_t in_data;
  out_item_t out_data;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;
  int fail_count, results_due;
  int idle_cycles = 0;
  bit calm = 1'b0;

  dc_motor_stiction_model_step u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dc_motor_stiction_model_step_check u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .results_due(results_due)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 27);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("dc_motor_stiction_model_step_test NOT OK");
        $finish;
      end
    end
  end

  function automatic in_item_t beat_of(input int dt, input logic signed [DATA_W-1:0] cmd,
                                       input logic signed [DATA_W-1:0] load);
    in_item_t b;
    b.time_step = DT_W'(dt);
    b.torque_command = cmd;
    b.load_torque = load;
    return b;
  endfunction

  function automatic logic signed [DATA_W-1:0] signed_span(input int r);
    int v;
    v = $urandom_range(0, 2 * r);
    return v - r;
  endfunction

  function automatic logic signed [DATA_W-1:0] extreme_word();
    case ($urandom_range(0, 4))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t random_beat();
    in_item_t b;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      b.time_step = DT_W'($urandom_range(0, 2048));
      b.torque_command = signed_span(4 << 16);
      b.load_torque = signed_span(2 << 16);
    end else if (roll < 85) begin
      b.time_step = DT_W'($urandom_range(0, 131071));
      b.torque_command = $urandom;
      b.load_torque = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0: b.time_step = '0;
        1: b.time_step = DT_W'(65536);
        2: b.time_step = '1;
        default: b.time_step = DT_W'($urandom_range(0, 131071));
      endcase
      b.torque_command = extreme_word();
      b.load_torque = extreme_word();
    end
    return b;
  endfunction

  function automatic logic [REG_W-1:0] pick_reg(input int zero_pct, input int max_pct,
                                                input int span);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < zero_pct) return '0;
    if (roll < zero_pct + max_pct) return REG_MAX;
    if (roll < zero_pct + max_pct + 5) return REG_W'($urandom);
    return REG_W'($urandom_range(0, span));
  endfunction

  function automatic motor_cfg_t random_settings();
    motor_cfg_t s;
    int roll;
    s.torque_limit = pick_reg(5, 10, 8 << 16);
    s.friction_torque = pick_reg(20, 5, 16 << 16);
    s.damping = pick_reg(20, 5, 4 << 16);
    s.inertia = pick_reg(5, 5, 4 << 16);
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      s.position_min = Q_MIN;
      s.position_max = Q_MAX;
    end else if (roll < 20) begin
      s.position_min = $urandom;
      s.position_max = $urandom;
    end else if (roll < 30) begin
      // crossed limits
      s.position_min = $urandom_range(1, 4 << 16);
      s.position_max = 0 - $urandom_range(0, 4 << 16);
    end else begin
      s.position_min = 0 - $urandom_range(0, 8 << 16);
      s.position_max = $urandom_range(0, 8 << 16);
    end
    return s;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
  endtask

  task automatic load_settings(input motor_cfg_t s, input bit with_unmapped);
    write_reg(REG_TORQUE_LIMIT, {1'($urandom), s.torque_limit});
    write_reg(REG_FRICTION_TORQUE, {1'($urandom), s.friction_torque});
    write_reg(REG_DAMPING, {1'($urandom), s.damping});
    write_reg(REG_INERTIA, {1'($urandom), s.inertia});
    write_reg(REG_POSITION_MIN, s.position_min);
    write_reg(REG_POSITION_MAX, s.position_max);
    if (with_unmapped) begin
      write_reg(REG_UNMAPPED_LO, $urandom);
      write_reg(REG_UNMAPPED_HI, $urandom);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drive_motor_beat(input in_item_t beat);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  initial begin
    motor_cfg_t s;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // register defaults after reset: command clamp and both position limits
    drive_motor_beat(beat_of(0, 0, 0));
    drive_motor_beat(beat_of(65536, Q_MAX, 0));
    drive_motor_beat(beat_of(65536, 0, 0));
    drive_motor_beat(beat_of(131071, Q_MIN, Q_MAX));
    drive_motor_beat(beat_of(131071, -1, Q_MIN));
    drive_motor_beat(beat_of(1, -Q_ONE, Q_ONE));
    wait_for_results();

    // zero inertia, widest limits, full friction: saturation everywhere
    s = '{REG_MAX, REG_MAX, '0, '0, Q_MIN, Q_MAX};
    load_settings(s, 1'b0);
    repeat (3) drive_motor_beat(beat_of(65536, Q_MAX, Q_MAX));
    repeat (3) drive_motor_beat(beat_of(65536, Q_MIN, Q_MIN));
    repeat (2) drive_motor_beat(beat_of(131071, Q_MAX, 0));
    wait_for_results();

    // crossed limits, zero torque limit, full damping and inertia, unmapped indexes
    s = '{'0, 31'd5000, REG_MAX, REG_MAX, Q_ONE, -Q_ONE};
    load_settings(s, 1'b1);
    drive_motor_beat(beat_of(0, Q_MAX, 0));
    drive_motor_beat(beat_of(65536, Q_MIN, Q_ONE));
    drive_motor_beat(beat_of(65536, Q_ONE, Q_MAX));
    drive_motor_beat(beat_of(4096, -Q_ONE, Q_MIN));
    wait_for_results();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_settings(random_settings(), p[0]);
      calm = (p == 2);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (p == 3 && k == PHASE_BEATS / 2) wait_for_results();
        drive_motor_beat(random_beat());
      end
      wait_for_results();
    end
    calm = 1'b0;

    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("dc_motor_stiction_model_step_test OK");
    end else begin
      $display("dc_motor_stiction_model_step_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/dcms_pkg.sv
hdl/dcms_div.sv
hdl/dcms_mul.sv
hdl/dc_motor_stiction_model_step.sv
tb/dc_motor_stiction_model_step_check.sv
tb/dc_motor_stiction_model_step_test.sv
